### hw/rtl/cbgc_pkg.sv
`timescale 1ns / 1ps
package cbgc_pkg;
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;
  localparam logic [1:0] KIND_STAMP  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] die_index;
    logic [9:0] block_index;
    logic [7:0] invalid_count;
  } cbgc_req_t;

  typedef struct packed {
    logic [9:0]  victim_block;
    logic        victim_found;
    logic [31:0] victim_score;
  } cbgc_rsp_t;
endpackage

### hw/rtl/cbgc_req_if.sv
`timescale 1ns / 1ps
interface cbgc_req_if;
  logic               valid;
  logic               ready;
  cbgc_pkg::cbgc_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/cbgc_rsp_if.sv
`timescale 1ns / 1ps
interface cbgc_rsp_if;
  logic               valid;
  logic               ready;
  cbgc_pkg::cbgc_rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/cbgc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module cbgc_div #(
  parameter int NW = 52,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

### hw/rtl/cost_benefit_gc_victim_select_unit.sv
`timescale 1ns / 1ps
// Cost-benefit garbage-collection victim selector.
// Channels: in_ carries one request word (kind, die, block, invalid count),
// out_ returns exactly one result word per request. Valid/ready handshake.
// Kinds: insert appends a block to the tail of its per-die bin list, remove
// unlinks it, stamp records the current activity tick as its erase time,
// select scans bins from full down to 1, head to tail, and detaches the
// block with the first strictly highest nonzero score.
// One request at a time; a new request is taken only once the result word
// has been taken. An out-of-range request is answered directly; the others
// go through the single-port link memories, which have registered reads:
// stamp writes the erase time, remove reads and unlinks a listed block, and
// insert reads, unlinks a listed block and appends the block to its bin.
// Select scores each listed block with the bit-serial score divider
// (numerator width NUMW = 48 by default), walks the bins in turn and then
// detaches a found victim.
// After reset a clearing pass sweeps the memories one entry a cycle over
// max(DIES*BLOCKS_PER_DIE, DIES*(PAGES_PER_BLOCK+1)) entries (8192 by default),
// emptying bin heads/tails and zeroing erase stamps and listed flags; no
// request is accepted during it. If the receiver stalls, the result is held
// in the output register and the next request waits until it is taken.
module cost_benefit_gc_victim_select_unit #(
  parameter int DIES = 8,
  parameter int BLOCKS_PER_DIE = 1024,
  parameter int PAGES_PER_BLOCK = 128
) (
  input logic clk,
  input logic rst_n,
  cbgc_req_if.sink   in_req,
  cbgc_rsp_if.source out_rsp
);
  localparam int BINS = PAGES_PER_BLOCK + 1;
  localparam int BW = $clog2(BLOCKS_PER_DIE + 1);   // link width incl. none
  localparam int DWD = (DIES > 1) ? $clog2(DIES) : 1;
  localparam int NSLOT = DIES * BLOCKS_PER_DIE;
  localparam int SW = $clog2(NSLOT);
  localparam int NBS = DIES * BINS;
  localparam int HW = $clog2(NBS);
  localparam int NBW = $clog2(PAGES_PER_BLOCK + 1);
  localparam int PW = $clog2(PAGES_PER_BLOCK + 1);
  localparam int NUMW = 32 + NBW + PW;
  localparam int CLRN = (NSLOT > NBS) ? NSLOT : NBS;
  localparam int CLW = $clog2(CLRN + 1);
  localparam logic [BW-1:0] NONE = BW'(BLOCKS_PER_DIE);

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_RD = 5'd2,
    S_UL0 = 5'd3, S_UL1 = 5'd4, S_UL2 = 5'd5, S_AP0 = 5'd6, S_AP1 = 5'd7,
    S_AP2 = 5'd8, S_OUT = 5'd9, S_SB = 5'd10, S_SBW = 5'd11,
    S_SBLK = 5'd12, S_SMUL = 5'd13, S_SMUL2 = 5'd14, S_SDIV = 5'd15,
    S_SNEXT = 5'd16, S_SDONE = 5'd17, S_RDW = 5'd18, S_STW = 5'd19,
    S_SMUL3 = 5'd20, S_SMUL4 = 5'd21;

  // memories
  logic [BW-1:0]  head_mem [NBS];
  logic [BW-1:0]  tail_mem [NBS];
  logic [BW-1:0]  next_mem [NSLOT];
  logic [BW-1:0]  prev_mem [NSLOT];
  logic [NBW-1:0] bin_mem  [NSLOT];
  logic [31:0]    stamp_mem[NSLOT];
  logic           listed_mem[NSLOT];

  logic [4:0]  st_r;
  logic [CLW-1:0] clr_r;
  logic [1:0]  kind_r;
  logic [DWD-1:0] die_r;
  logic [BW-1:0] blk_r;
  logic [NBW-1:0] cnt_r;
  logic [31:0] tick_r;
  logic [BW-1:0] nx_r, pv_r, tl_r, cur_r, best_r;
  logic [NBW-1:0] ob_r, sbin_r;
  logic [31:0] best_score_r, age1_r;
  logic [NBW+31:0] prod1_r;
  logic [NUMW-1:0] num_r;
  logic [BW-1:0] steps_r;
  logic out_valid_r;
  cbgc_pkg::cbgc_rsp_t out_r;

  // memory read data
  logic [BW-1:0]  head_q, tail_q, next_q, prev_q;
  logic [NBW-1:0] bin_q;
  logic [31:0]    stamp_q;
  logic           listed_q;

  // memory ports (one access each per cycle)
  logic hb_we, tb_we, nx_we, pv_we, bn_we, sm_we, ls_we;
  logic [HW-1:0] hb_a;
  logic [SW-1:0] nx_a, pv_a, sm_a, ls_a;
  logic [BW-1:0] hb_wd, tb_wd, nx_wd, pv_wd;
  logic [31:0]   sm_wd;
  logic          ls_wd;

  logic div_start, div_done;
  logic [NUMW-1:0] div_q;

  function automatic logic [SW-1:0] slot_of(input logic [DWD-1:0] d,
                                            input logic [BW-1:0] b);
    return SW'(d * BLOCKS_PER_DIE) + SW'(b);
  endfunction

  function automatic logic [HW-1:0] bslot_of(input logic [DWD-1:0] d,
                                             input logic [NBW-1:0] b);
    return HW'(d * BINS) + HW'(b);
  endfunction

  logic [SW-1:0] slot_me;
  assign slot_me = slot_of(die_r, blk_r);

  always_ff @(posedge clk) begin
    if (hb_we) head_mem[hb_a] <= hb_wd;
    if (tb_we) tail_mem[hb_a] <= tb_wd;
    head_q <= head_mem[hb_a];
    tail_q <= tail_mem[hb_a];
    if (nx_we) next_mem[nx_a] <= nx_wd;
    next_q <= next_mem[nx_a];
    if (pv_we) prev_mem[pv_a] <= pv_wd;
    prev_q <= prev_mem[pv_a];
    if (bn_we) bin_mem[pv_a] <= cnt_r;
    bin_q <= bin_mem[pv_a];
    if (sm_we) stamp_mem[sm_a] <= sm_wd;
    stamp_q <= stamp_mem[sm_a];
    if (ls_we) listed_mem[ls_a] <= ls_wd;
    listed_q <= listed_mem[ls_a];
  end

  cbgc_div #(.NW(NUMW), .DW(PW + 1)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_r), .den((PW + 1)'(PAGES_PER_BLOCK - sbin_r + 1)),
    .done(div_done), .quo(div_q)
  );

  logic accept;
  assign in_req.ready = (st_r == S_IDLE) && !out_valid_r;
  assign accept = in_req.valid && in_req.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.payload = out_r;

  // combinational port control
  always_comb begin
    hb_we = 1'b0; tb_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; bn_we = 1'b0;
    sm_we = 1'b0; ls_we = 1'b0;
    hb_a = '0; hb_wd = NONE; tb_wd = NONE;
    nx_a = slot_me; nx_wd = NONE;
    pv_a = slot_me; pv_wd = NONE;
    sm_a = slot_me; sm_wd = tick_r;
    ls_a = slot_me; ls_wd = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      S_CLR: begin
        if (clr_r < CLW'(NBS)) begin
          hb_a = HW'(clr_r); hb_we = 1'b1; tb_we = 1'b1;
        end
        if (clr_r < CLW'(NSLOT)) begin
          sm_a = SW'(clr_r); sm_we = 1'b1; sm_wd = '0;
          ls_a = SW'(clr_r); ls_we = 1'b1;
        end
      end
      S_STW: sm_we = 1'b1;
      S_UL0: begin
        // predecessor's next, or bin head
        hb_a = bslot_of(die_r, ob_r);
        if (pv_r < NONE) begin
          nx_a = slot_of(die_r, pv_r); nx_we = 1'b1; nx_wd = nx_r;
        end else begin
          hb_we = 1'b1; hb_wd = nx_r; tb_wd = tail_q;
        end
      end
      S_UL1: begin
        hb_a = bslot_of(die_r, ob_r);
        if (nx_r < NONE) begin
          pv_a = slot_of(die_r, nx_r); pv_we = 1'b1; pv_wd = pv_r;
        end else begin
          tb_we = 1'b1; tb_wd = pv_r;
        end
      end
      S_UL2: begin
        nx_we = 1'b1; pv_we = 1'b1; ls_we = 1'b1;
        hb_a = bslot_of(die_r, cnt_r);
      end
      S_AP0: hb_a = bslot_of(die_r, cnt_r);
      S_AP1: begin
        hb_a = bslot_of(die_r, cnt_r);
        pv_we = 1'b1; pv_wd = tail_q; bn_we = 1'b1;
        nx_we = 1'b1; nx_wd = NONE;
        tb_we = 1'b1; tb_wd = blk_r;
        if (tail_q >= NONE) begin
          hb_we = 1'b1; hb_wd = blk_r;
        end
      end
      S_AP2: begin
        ls_we = 1'b1; ls_wd = 1'b1;
        if (tl_r < NONE) begin
          nx_a = slot_of(die_r, tl_r); nx_we = 1'b1; nx_wd = blk_r;
        end
      end
      S_SB: hb_a = bslot_of(die_r, sbin_r);
      S_SBLK: begin
        nx_a = slot_of(die_r, cur_r); sm_a = slot_of(die_r, cur_r);
      end
      S_SMUL4: div_start = 1'b1;
      default: ;
    endcase
  end

  // same-cycle bin-head write during S_UL0 must keep tail: handled by
  // writing tail only when tb_we is set, so tb_wd there is unused.

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      tick_r <= '0;
      out_valid_r <= 1'b0;
      kind_r <= cbgc_pkg::KIND_INSERT;
    end else begin
      if (out_valid_r && out_rsp.ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLW'(CLRN - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            kind_r <= in_req.payload.kind;
            die_r <= DWD'(in_req.payload.die_index);
            blk_r <= BW'(in_req.payload.block_index);
            cnt_r <= NBW'(in_req.payload.invalid_count);
            out_r <= '0;
            if (32'(in_req.payload.die_index) >= 32'(DIES)) begin
              out_valid_r <= 1'b1;
            end else if (in_req.payload.kind == cbgc_pkg::KIND_SELECT) begin
              sbin_r <= NBW'(PAGES_PER_BLOCK);
              best_r <= NONE;
              best_score_r <= '0;
              st_r <= S_SB;
            end else if (32'(in_req.payload.block_index) >= 32'(BLOCKS_PER_DIE)
                || (in_req.payload.kind == cbgc_pkg::KIND_INSERT &&
                    32'(in_req.payload.invalid_count) > 32'(PAGES_PER_BLOCK))) begin
              out_valid_r <= 1'b1;
            end else if (in_req.payload.kind == cbgc_pkg::KIND_STAMP) begin
              st_r <= S_STW;
            end else begin
              if (in_req.payload.kind == cbgc_pkg::KIND_INSERT &&
                  in_req.payload.invalid_count != 8'd0) tick_r <= tick_r + 1'b1;
              st_r <= S_RD;
            end
          end
        end
        S_STW: st_r <= S_OUT;
        S_RD: st_r <= S_RDW;
        S_RDW: begin
          // next_q/prev_q/bin_q/listed_q valid now for the addressed block
          if (listed_q) begin
            nx_r <= next_q; pv_r <= prev_q;
            ob_r <= (bin_q > NBW'(PAGES_PER_BLOCK)) ? NBW'(PAGES_PER_BLOCK) : bin_q;
            st_r <= S_UL0;
          end else if (kind_r == cbgc_pkg::KIND_INSERT) begin
            st_r <= S_AP0;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_UL0: st_r <= S_UL1;
        S_UL1: st_r <= S_UL2;
        S_UL2: st_r <= (kind_r == cbgc_pkg::KIND_INSERT) ? S_AP0 : S_OUT;
        S_AP0: st_r <= S_AP1;
        S_AP1: begin
          tl_r <= tail_q;
          st_r <= S_AP2;
        end
        S_AP2: st_r <= S_OUT;
        S_OUT: begin
          if (kind_r == cbgc_pkg::KIND_SELECT) begin
            out_r.victim_block <= 10'(best_r);
            out_r.victim_found <= 1'b1;
            out_r.victim_score <= best_score_r;
          end
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_SB: st_r <= S_SBW;
        S_SBW: begin
          cur_r <= head_q;
          steps_r <= '0;
          st_r <= S_SNEXT;
        end
        S_SNEXT: begin
          if (cur_r < NONE && steps_r < NONE) st_r <= S_SBLK;
          else if (sbin_r == NBW'(1)) st_r <= S_SDONE;
          else begin
            sbin_r <= sbin_r - 1'b1;
            st_r <= S_SB;
          end
        end
        S_SBLK: st_r <= S_SMUL;
        S_SMUL: begin
          age1_r <= tick_r - stamp_q + 32'd1;
          nx_r <= next_q;
          st_r <= S_SMUL2;
        end
        // wait for the two product registers to settle
        S_SMUL2: st_r <= S_SMUL3;
        S_SMUL3: st_r <= S_SMUL4;
        S_SMUL4: st_r <= S_SDIV;
        S_SDIV: begin
          if (div_done) begin
            if (32'(div_q) > best_score_r) begin
              best_score_r <= 32'(div_q);
              best_r <= cur_r;
            end
            cur_r <= nx_r;
            steps_r <= steps_r + 1'b1;
            st_r <= S_SNEXT;
          end
        end
        S_SDONE: begin
          if (best_r < NONE) begin
            blk_r <= best_r;
            st_r <= S_RD;
          end else begin
            out_valid_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
    // multiply pipeline, one product per register
    prod1_r <= (NBW + 32)'(sbin_r) * (NBW + 32)'(age1_r);
    num_r <= NUMW'(prod1_r) * NUMW'(PAGES_PER_BLOCK);
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_req.ready)
    else $error("request taken while busy");
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.victim_found) |-> (out_r.victim_score != 32'd0))
    else $error("victim found with zero score");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |=> out_valid_r)
    else $error("result dropped");
`endif
endmodule

### verif/cost_benefit_gc_victim_select_unit_tb.sv
`timescale 1ns / 1ps
module cost_benefit_gc_victim_select_unit_tb;
  localparam int DIES = 8;
  localparam int BLOCKS_PER_DIE = 1024;
  localparam int PAGES_PER_BLOCK = 128;
  localparam int BINS = PAGES_PER_BLOCK + 1;
  localparam logic [10:0] NO_LINK = 11'(BLOCKS_PER_DIE);
  localparam int TAIL_ITEMS = 40;

  logic clk;
  logic rst_n;

  cbgc_req_if in_req();
  cbgc_rsp_if out_rsp();

  cost_benefit_gc_victim_select_unit #(
    .DIES(DIES),
    .BLOCKS_PER_DIE(BLOCKS_PER_DIE),
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req.sink),
    .out_rsp(out_rsp.source)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow of the victim lists
  logic [10:0] head_of [DIES][BINS];
  logic [10:0] tail_of [DIES][BINS];
  logic [10:0] next_of [DIES][BLOCKS_PER_DIE];
  logic [10:0] prev_of [DIES][BLOCKS_PER_DIE];
  logic [7:0]  bin_of [DIES][BLOCKS_PER_DIE];
  bit          on_list [DIES][BLOCKS_PER_DIE];
  logic [31:0] erased_at [DIES][BLOCKS_PER_DIE];
  logic [31:0] gc_tick;

  cbgc_pkg::cbgc_req_t pending_words[$];
  cbgc_pkg::cbgc_rsp_t expected_victims[$];
  int errors;
  int gap_left;
  int stall_left;
  bit req_fired;
  bit draining;

  task automatic report(input string what, input longint exp_v, input longint got_v);
    $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
    errors++;
  endtask

  task automatic detach(input int d, input int blk);
    logic [10:0] nx;
    logic [10:0] pv;
    int b;
    nx = next_of[d][blk];
    pv = prev_of[d][blk];
    b = bin_of[d][blk];
    if (pv < NO_LINK) next_of[d][pv] = nx;
    else head_of[d][b] = nx;
    if (nx < NO_LINK) prev_of[d][nx] = pv;
    else tail_of[d][b] = pv;
    next_of[d][blk] = NO_LINK;
    prev_of[d][blk] = NO_LINK;
    on_list[d][blk] = 0;
  endtask

  task automatic attach(input int d, input int blk, input int b);
    logic [10:0] tl;
    tl = tail_of[d][b];
    prev_of[d][blk] = tl;
    next_of[d][blk] = NO_LINK;
    if (tl < NO_LINK) next_of[d][tl] = 11'(blk);
    else head_of[d][b] = 11'(blk);
    tail_of[d][b] = 11'(blk);
    bin_of[d][blk] = 8'(b);
    on_list[d][blk] = 1;
  endtask

  function automatic logic [31:0] benefit_score(input int d, input int blk, input int b);
    logic [31:0] age1;
    logic [63:0] gain;
    age1 = gc_tick - erased_at[d][blk] + 32'd1;
    gain = 64'(b) * 64'(age1) * 64'(PAGES_PER_BLOCK);
    return 32'(gain / (64'(PAGES_PER_BLOCK - b) + 64'd1));
  endfunction

  task automatic predict_victim(input cbgc_pkg::cbgc_req_t w,
                                output cbgc_pkg::cbgc_rsp_t r);
    int d;
    int blk;
    int best;
    logic [31:0] best_score;
    logic [31:0] s;
    logic [10:0] cur;
    d = w.die_index;
    blk = w.block_index;
    r = '0;
    if (d >= DIES) return;
    if (w.kind == cbgc_pkg::KIND_SELECT) begin
      best = NO_LINK;
      best_score = 0;
      for (int b = PAGES_PER_BLOCK; b > 0; b--) begin
        cur = head_of[d][b];
        while (cur < NO_LINK) begin
          s = benefit_score(d, cur, b);
          if (s > best_score) begin
            best_score = s;
            best = cur;
          end
          cur = next_of[d][cur];
        end
      end
      if (best < NO_LINK) begin
        detach(d, best);
        r.victim_block = 10'(best);
        r.victim_found = 1'b1;
        r.victim_score = best_score;
      end
      return;
    end
    if (blk >= BLOCKS_PER_DIE) return;
    case (w.kind)
      cbgc_pkg::KIND_INSERT: begin
        if (w.invalid_count <= PAGES_PER_BLOCK) begin
          if (w.invalid_count != 0) gc_tick++;
          if (on_list[d][blk]) detach(d, blk);
          attach(d, blk, w.invalid_count);
        end
      end
      cbgc_pkg::KIND_REMOVE: begin
        if (on_list[d][blk]) detach(d, blk);
      end
      default: erased_at[d][blk] = gc_tick;
    endcase
  endtask

  function automatic cbgc_pkg::cbgc_req_t mk(input logic [1:0] k, input int d,
                                             input int blk, input int cnt);
    cbgc_pkg::cbgc_req_t w;
    w.kind = k;
    w.die_index = 3'(d);
    w.block_index = 10'(blk);
    w.invalid_count = 8'(cnt);
    return w;
  endfunction

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    cbgc_pkg::cbgc_rsp_t want;
    cbgc_pkg::cbgc_rsp_t got;
    req_fired = 0;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        req_fired = 1;
        predict_victim(in_req.payload, want);
        expected_victims.push_back(want);
      end
      if (out_rsp.valid && out_rsp.ready) begin
        got = out_rsp.payload;
        if (expected_victims.size() == 0) begin
          report("unexpected result, block", 0, got.victim_block);
        end else begin
          want = expected_victims.pop_front();
          if (got.victim_block !== want.victim_block)
            report("victim_block", want.victim_block, got.victim_block);
          if (got.victim_found !== want.victim_found)
            report("victim_found", want.victim_found, got.victim_found);
          if (got.victim_score !== want.victim_score)
            report("victim_score", want.victim_score, got.victim_score);
        end
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_req.valid || req_fired)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_req.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_req.payload <= pending_words.pop_front();
        in_req.valid <= 1'b1;
        if (pending_words.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
          gap_left <= $urandom_range(1, 18);
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // result sink with stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (draining || pending_words.size() <= TAIL_ITEMS) begin
        out_rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 17);
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int k;
    int d;
    int blk;
    int cnt;
    errors = 0;
    gap_left = 0;
    stall_left = 0;
    draining = 0;
    in_req.valid = 1'b0;
    in_req.payload = '0;
    out_rsp.ready = 1'b0;
    gc_tick = 0;
    for (int i = 0; i < DIES; i++) begin
      for (int b = 0; b < BINS; b++) begin
        head_of[i][b] = NO_LINK;
        tail_of[i][b] = NO_LINK;
      end
      for (int j = 0; j < BLOCKS_PER_DIE; j++) begin
        next_of[i][j] = NO_LINK;
        prev_of[i][j] = NO_LINK;
        bin_of[i][j] = 0;
        on_list[i][j] = 0;
        erased_at[i][j] = 0;
      end
    end

    // directed part
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 0, 0, 0));    // empty die
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 5, 0));    // bin zero, no tick
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 6, 1));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 7, 128));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 8, 129));  // bin out of range
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 9, 255));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 10, 64));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 11, 64));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 12, 64));
    pending_words.push_back(mk(cbgc_pkg::KIND_REMOVE, 0, 11, 0));   // middle
    pending_words.push_back(mk(cbgc_pkg::KIND_REMOVE, 0, 10, 0));   // head
    pending_words.push_back(mk(cbgc_pkg::KIND_REMOVE, 0, 300, 0));  // not listed
    pending_words.push_back(mk(cbgc_pkg::KIND_STAMP, 0, 7, 0));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 0, 6, 100));  // move listed block
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 7, 1023, 128));
    pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, 7, 512, 3));
    pending_words.push_back(mk(cbgc_pkg::KIND_STAMP, 7, 1023, 255));
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 0, 1023, 255));
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 0, 0, 0));
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 7, 0, 0));
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 7, 0, 0));
    pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, 0, 0, 0));    // leaves only bin zero
    pending_words.push_back(mk(cbgc_pkg::KIND_REMOVE, 0, 5, 0));

    // random part
    for (int n = 0; n < 270; n++) begin
      k = $urandom_range(0, 99);
      d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 2);
      blk = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
      case ($urandom_range(0, 9))
        0: cnt = 0;
        1: cnt = $urandom_range(129, 255);
        2: cnt = PAGES_PER_BLOCK;
        default: cnt = $urandom_range(1, 128);
      endcase
      if (k < 45)
        pending_words.push_back(mk(cbgc_pkg::KIND_INSERT, d, blk, cnt));
      else if (k < 60)
        pending_words.push_back(mk(cbgc_pkg::KIND_REMOVE, d, blk, $urandom_range(0, 255)));
      else if (k < 80)
        pending_words.push_back(mk(cbgc_pkg::KIND_SELECT, d, blk, $urandom_range(0, 255)));
      else
        pending_words.push_back(mk(cbgc_pkg::KIND_STAMP, d, blk, $urandom_range(0, 255)));
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_words.size() == 0);
    draining = 1;
    while (in_req.valid || expected_victims.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
